/* src/crcfp_pkg.sv */
// Shared constants, codes and types of the framed packet parser.
package crcfp_pkg;

    localparam int MAX_PAYLOAD = 64;
    localparam int PAY_AW      = 6;   // payload RAM address width
    localparam int LEN_W       = 7;   // length field width, holds MAX_PAYLOAD

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    localparam logic [7:0] RST_SOF1    = 8'hAA;
    localparam logic [7:0] RST_SOF2    = 8'h55;
    localparam logic [7:0] RST_VERSION = 8'h01;

    // configuration register indexes
    localparam logic [1:0] CFG_SOF1    = 2'd0;
    localparam logic [1:0] CFG_SOF2    = 2'd1;
    localparam logic [1:0] CFG_VERSION = 2'd2;

    typedef enum logic [2:0] {
        STAT_NONE    = 3'd0,
        STAT_FRAME   = 3'd1,
        STAT_VER_ERR = 3'd2,
        STAT_LEN_ERR = 3'd3,
        STAT_CRC_ERR = 3'd4
    } t_status;

    typedef enum logic [3:0] {
        RX_HUNT,
        RX_SOF2,
        RX_VER,
        RX_TYPE,
        RX_SEQ,
        RX_LEN,
        RX_PAY,
        RX_CRC_LO,
        RX_CRC_HI
    } t_rx_state;

    typedef enum logic [1:0] {
        TX_IDLE,
        TX_RD,
        TX_OUT,
        TX_ONE
    } t_tx_state;

    // frame outcome handed from the receiver to the release sequencer
    typedef struct packed {
        logic             valid;
        t_status          status;
        logic [7:0]       ftype;
        logic [7:0]       seq;
        logic [LEN_W-1:0] len;
    } t_rel_req;

endpackage

/* src/crcfp_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module crcfp_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic                     i_rd_en,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* src/crcfp_rx.sv */
// Receive side: start-byte hunt, header capture, CRC, payload write, error counters.
module crcfp_rx
    import crcfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata,
    input  logic              i_acc,
    input  logic [7:0]        i_rx_byte,
    output logic              o_wr_en,
    output logic [PAY_AW-1:0] o_wr_addr,
    output logic [7:0]        o_wr_data,
    output t_rel_req          o_req,
    output logic [15:0]       o_verr,
    output logic [15:0]       o_lerr,
    output logic [15:0]       o_cerr
);

    t_rx_state         r_state, n_state;
    logic [7:0]        r_sof1, r_sof2, r_exp_ver;
    logic [PAY_AW-1:0] r_off, n_off;
    logic [15:0]       r_crc, n_crc;
    logic [7:0]        r_ver, n_ver;
    logic [7:0]        r_type, n_type;
    logic [7:0]        r_seq, n_seq;
    logic [LEN_W-1:0]  r_len, n_len;
    logic [7:0]        r_trl_lo, n_trl_lo;
    logic [15:0]       r_verr, n_verr;
    logic [15:0]       r_lerr, n_lerr;
    logic [15:0]       r_cerr, n_cerr;
    logic [15:0]       crc_upd;
    logic              hdr_bad_ver, hdr_bad_len, pay_last;

    // MSB-first CRC-16, one byte
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {b, 8'h00};
        for (int k = 0; k < 8; k++) begin
            c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
        end
        return c;
    endfunction

    assign crc_upd     = crc16_byte(r_crc, i_rx_byte);
    assign hdr_bad_ver = (r_ver != r_exp_ver);
    assign hdr_bad_len = (i_rx_byte > 8'(MAX_PAYLOAD));
    assign pay_last    = ({1'b0, r_off} == (r_len - LEN_W'(1)));

    // next state
    always_comb begin
        n_state = r_state;
        if (i_acc) begin
            unique case (r_state)
                RX_HUNT: begin
                    if (i_rx_byte == r_sof1) n_state = RX_SOF2;
                end
                RX_SOF2: begin
                    if (i_rx_byte == r_sof2)      n_state = RX_VER;
                    else if (i_rx_byte != r_sof1) n_state = RX_HUNT;
                end
                RX_VER:  n_state = RX_TYPE;
                RX_TYPE: n_state = RX_SEQ;
                RX_SEQ:  n_state = RX_LEN;
                RX_LEN: begin
                    if (hdr_bad_ver || hdr_bad_len) n_state = RX_HUNT;
                    else if (i_rx_byte == 8'd0)     n_state = RX_CRC_LO;
                    else                            n_state = RX_PAY;
                end
                RX_PAY: begin
                    if (pay_last) n_state = RX_CRC_LO;
                end
                RX_CRC_LO: n_state = RX_CRC_HI;
                RX_CRC_HI: n_state = RX_HUNT;
                default:   n_state = RX_HUNT;
            endcase
        end
    end

    // datapath and outputs
    always_comb begin
        n_off    = r_off;
        n_crc    = r_crc;
        n_ver    = r_ver;
        n_type   = r_type;
        n_seq    = r_seq;
        n_len    = r_len;
        n_trl_lo = r_trl_lo;
        n_verr   = r_verr;
        n_lerr   = r_lerr;
        n_cerr   = r_cerr;
        o_req    = '0;
        o_wr_en  = 1'b0;
        if (i_acc) begin
            unique case (r_state)
                RX_HUNT: ;
                RX_SOF2: n_crc = CRC_INIT;
                RX_VER: begin
                    n_crc = crc_upd;
                    n_ver = i_rx_byte;
                end
                RX_TYPE: begin
                    n_crc  = crc_upd;
                    n_type = i_rx_byte;
                end
                RX_SEQ: begin
                    n_crc = crc_upd;
                    n_seq = i_rx_byte;
                end
                RX_LEN: begin
                    n_crc = crc_upd;
                    if (hdr_bad_ver) begin
                        n_verr       = r_verr + 16'd1;
                        o_req.valid  = 1'b1;
                        o_req.status = STAT_VER_ERR;
                    end else if (hdr_bad_len) begin
                        n_lerr       = r_lerr + 16'd1;
                        o_req.valid  = 1'b1;
                        o_req.status = STAT_LEN_ERR;
                    end else begin
                        n_len = i_rx_byte[LEN_W-1:0];
                        n_off = '0;
                    end
                end
                RX_PAY: begin
                    o_wr_en = 1'b1;
                    n_crc   = crc_upd;
                    n_off   = r_off + PAY_AW'(1);
                end
                RX_CRC_LO: n_trl_lo = i_rx_byte;
                RX_CRC_HI: begin
                    o_req.valid = 1'b1;
                    if ({i_rx_byte, r_trl_lo} != r_crc) begin
                        n_cerr       = r_cerr + 16'd1;
                        o_req.status = STAT_CRC_ERR;
                    end else begin
                        o_req.status = STAT_FRAME;
                        o_req.ftype  = r_type;
                        o_req.seq    = r_seq;
                        o_req.len    = r_len;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_wr_addr = r_off;
    assign o_wr_data = i_rx_byte;
    assign o_verr    = r_verr;
    assign o_lerr    = r_lerr;
    assign o_cerr    = r_cerr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= RX_HUNT;
            r_off     <= '0;
            r_crc     <= CRC_INIT;
            r_verr    <= '0;
            r_lerr    <= '0;
            r_cerr    <= '0;
            r_sof1    <= RST_SOF1;
            r_sof2    <= RST_SOF2;
            r_exp_ver <= RST_VERSION;
        end else begin
            r_state <= n_state;
            r_off   <= n_off;
            r_crc   <= n_crc;
            r_verr  <= n_verr;
            r_lerr  <= n_lerr;
            r_cerr  <= n_cerr;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_SOF1:    r_sof1    <= i_cfg_wdata;
                    CFG_SOF2:    r_sof2    <= i_cfg_wdata;
                    CFG_VERSION: r_exp_ver <= i_cfg_wdata;
                    default: ;
                endcase
            end
        end
    end

    // header and trailer holding registers
    always_ff @(posedge i_clk) begin
        r_ver    <= n_ver;
        r_type   <= n_type;
        r_seq    <= n_seq;
        r_len    <= n_len;
        r_trl_lo <= n_trl_lo;
    end

endmodule

/* src/crcfp_tx.sv */
// Release sequencer: reads the payload RAM and drives the result channel.
module crcfp_tx
    import crcfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_rel_req          i_req,
    output logic              o_idle,
    output logic              o_rd_en,
    output logic [PAY_AW-1:0] o_rd_addr,
    input  logic [7:0]        i_rd_data,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [7:0]        o_frame_type,
    output logic [7:0]        o_sequence_res,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [7:0]        o_payload_byte,
    output logic [PAY_AW-1:0] o_payload_position,
    output logic              o_last
);

    t_tx_state         r_state, n_state;
    t_status           r_status;
    logic [7:0]        r_type, r_seq;
    logic [LEN_W-1:0]  r_len;
    logic [PAY_AW-1:0] r_idx, n_idx;
    logic              last_byte, step;

    assign last_byte = ({1'b0, r_idx} == (r_len - LEN_W'(1)));
    assign step      = (r_state == TX_OUT) && i_ready && !last_byte;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            TX_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.status == STAT_FRAME && i_req.len != '0) n_state = TX_RD;
                    else                                               n_state = TX_ONE;
                end
            end
            TX_RD:  n_state = TX_OUT;
            TX_OUT: begin
                if (i_ready && last_byte) n_state = TX_IDLE;
            end
            TX_ONE: begin
                if (i_ready) n_state = TX_IDLE;
            end
            default: n_state = TX_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_idle  = (r_state == TX_IDLE);
        o_valid = (r_state == TX_OUT) || (r_state == TX_ONE);
        o_rd_en = (r_state == TX_RD) || step;
        if (r_state == TX_IDLE) n_idx = '0;
        else if (step)          n_idx = r_idx + PAY_AW'(1);
        else                    n_idx = r_idx;
        o_rd_addr = n_idx;
    end

    assign o_status           = r_status;
    assign o_frame_type       = r_type;
    assign o_sequence_res     = r_seq;
    assign o_payload_length   = r_len;
    assign o_payload_byte     = (r_state == TX_OUT) ? i_rd_data : 8'd0;
    assign o_payload_position = r_idx;
    assign o_last             = (r_state == TX_ONE) || ((r_state == TX_OUT) && last_byte);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= TX_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == TX_IDLE && i_req.valid) begin
            r_status <= i_req.status;
            r_type   <= i_req.ftype;
            r_seq    <= i_req.seq;
            r_len    <= i_req.len;
        end
    end

`ifndef SYNTH
    // receiver must never finish a frame while a release is in flight
    a_req_only_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != TX_IDLE) |-> !i_req.valid)
        else $error("frame outcome arrived while release busy");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_last) |=> (r_state == TX_IDLE))
        else $error("release did not end after last transfer");

    a_err_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != STAT_FRAME) |-> (o_last && o_payload_length == '0))
        else $error("error result not a single empty transfer");

    a_rd_first: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == TX_RD) |=> (r_state == TX_OUT && r_idx == '0))
        else $error("payload release did not start at entry zero");
`endif

endmodule

/* src/crc16_framed_packet_parser.sv */
// Top level of the SOF/length framed packet parser with CRC-16/CCITT-FALSE check.
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------------------
//  rx bytes  | in        | i_valid / o_ready   | i_rx_byte
//  results   | out       | o_valid / i_ready   | o_status .. o_crc_error_total
//  config    | in        | i_cfg_we (no wait)  | i_cfg_idx, i_cfg_wdata
//
// Bytes are taken one per cycle while a frame is being received.
// On the closing CRC byte (on the length byte for a version or length error), the
// frame outcome goes to the release sequencer; o_ready stays low until its final
// result transfer. An error or empty frame is one result; N payload bytes give N
// results, read from the payload RAM (first read in TX_RD), one result per cycle
// while i_ready is high. Stalls on i_ready hold the result and extend the release.
// Reset (synchronous, active low) clears the parser state, the error counters and
// restores the default start bytes and version; the payload RAM is not cleared.
module crc16_framed_packet_parser
    import crcfp_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration writes
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_idx,
    input  logic [7:0]        i_cfg_wdata,
    // received bytes
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [7:0]        i_rx_byte,
    // results
    output logic              o_valid,
    input  logic              i_ready,
    output logic [2:0]        o_status,
    output logic [7:0]        o_frame_type,
    output logic [7:0]        o_sequence_res,
    output logic [LEN_W-1:0]  o_payload_length,
    output logic [7:0]        o_payload_byte,
    output logic [PAY_AW-1:0] o_payload_position,
    output logic              o_last,
    output logic [15:0]       o_version_error_total,
    output logic [15:0]       o_length_error_total,
    output logic [15:0]       o_crc_error_total
);

    t_rel_req          rel_req;
    logic              tx_idle;
    logic              rx_acc;
    logic              wr_en, rd_en;
    logic [PAY_AW-1:0] wr_addr, rd_addr;
    logic [7:0]        wr_data, rd_data;

    // byte input is held off for the whole release, so RAM writes of the
    // next frame cannot overtake reads of the current one
    assign o_ready = tx_idle;
    assign rx_acc  = i_valid && o_ready;

    crcfp_rx u_rx (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_acc       (rx_acc),
        .i_rx_byte   (i_rx_byte),
        .o_wr_en     (wr_en),
        .o_wr_addr   (wr_addr),
        .o_wr_data   (wr_data),
        .o_req       (rel_req),
        .o_verr      (o_version_error_total),
        .o_lerr      (o_length_error_total),
        .o_cerr      (o_crc_error_total)
    );

    // payload buffer, one entry per payload byte
    crcfp_ram #(
        .DEPTH (MAX_PAYLOAD),
        .WIDTH (8)
    ) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    // counters stay stable during a release since no byte is accepted then
    crcfp_tx u_tx (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_req              (rel_req),
        .o_idle             (tx_idle),
        .o_rd_en            (rd_en),
        .o_rd_addr          (rd_addr),
        .i_rd_data          (rd_data),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_status           (o_status),
        .o_frame_type       (o_frame_type),
        .o_sequence_res     (o_sequence_res),
        .o_payload_length   (o_payload_length),
        .o_payload_byte     (o_payload_byte),
        .o_payload_position (o_payload_position),
        .o_last             (o_last)
    );

endmodule
